/* hw/rtl/rrq_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler package
// Shared defaults and the command and status bundles that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rrq_pkg;

  // Default ring depth.
  localparam int MAX_PROCESSES_DEF = 16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input word
    logic enqueue;  // append or reject, and load the result
    logic finished; // load the all-finished result
    logic skip;     // head entry is finished, step the head on
    logic serve;    // serve the head entry and load the result
  } rrq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic none_left; // no loaded entry has time left
    logic rem_zero;  // registered head entry has no time left
    logic out_free;  // result register can take a word this cycle
  } rrq_sts_t;

endpackage

/* hw/rtl/rrq_ctrl.sv */
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler controller
// Sequences one word at a time: enqueue, all-finished, or a scan and serve.
// ----------------------------------------------------------------------------
module rrq_ctrl
  import rrq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_stall,
  output rrq_cmd_t cmd,
  input  rrq_sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ENQ   = 3'd1;
  localparam logic [2:0] S_FIN   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;

  localparam logic KIND_ENQUEUE = 1'b0;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_kind == KIND_ENQUEUE) begin
            state_nxt = S_ENQ;
          end else if (sts.none_left) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_ENQ: begin
        if (sts.out_free) begin
          cmd.enqueue = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finished = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.rem_zero) begin
          cmd.skip  = 1'b1;
          state_nxt = S_READ;
        end else if (sts.out_free) begin
          cmd.serve = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/rrq_datapath.sv */
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler datapath
// Entry memories, ring pointers, quantum register and the result register.
// ----------------------------------------------------------------------------
module rrq_datapath
  import rrq_pkg::*;
#(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rrq_cmd_t    cmd,
  output rrq_sts_t    sts,
  input  logic [15:0] in_proc_id,
  input  logic [15:0] in_arrival_time,
  input  logic [15:0] in_burst_time,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_served_id,
  output logic [15:0] out_served_arrival,
  output logic [15:0] out_served_remaining,
  output logic [15:0] out_slice_used,
  output logic        out_all_done
);

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_PROCESSES);

  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_SERVED   = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  // Entry memories, read at the head pointer with registered data.
  logic [15:0] mem_id  [MAX_PROCESSES];
  logic [15:0] mem_arr [MAX_PROCESSES];
  logic [15:0] mem_rem [MAX_PROCESSES];
  logic [15:0] rd_id_r, rd_arr_r, rd_rem_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] unfin_r, unfin_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] head_inc;
  logic [15:0]      quantum_r;
  logic [15:0]      pid_r, parr_r, pburst_r;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [15:0]      sid_r, sid_nxt, sarr_r, sarr_nxt;
  logic [15:0]      srem_r, srem_nxt, slice_r, slice_nxt;
  logic             done_r, done_nxt;

  logic             full;
  logic [15:0]      slice;
  logic [15:0]      rem_after;
  logic             enq_wr;
  logic             rem_wr;
  logic [IDX_W-1:0] rem_addr;
  logic [15:0]      rem_data;

  assign full      = (count_r == FULL_CNT);
  assign slice     = (rd_rem_r > quantum_r) ? quantum_r : rd_rem_r;
  assign rem_after = rd_rem_r - slice;
  assign head_inc  = ((CNT_W'(head_r) + CNT_W'(1)) == count_r) ? '0 : head_r + IDX_W'(1);

  assign enq_wr   = cmd.enqueue && !full;
  assign rem_wr   = enq_wr || cmd.serve;
  assign rem_addr = cmd.serve ? head_r : count_r[IDX_W-1:0];
  assign rem_data = cmd.serve ? rem_after : pburst_r;

  assign sts.none_left = (unfin_r == '0);
  assign sts.rem_zero  = (rd_rem_r == 16'd0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    count_nxt     = count_r;
    unfin_nxt     = unfin_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    sid_nxt       = sid_r;
    sarr_nxt      = sarr_r;
    srem_nxt      = srem_r;
    slice_nxt     = slice_r;
    done_nxt      = done_r;

    if (cmd.skip) begin
      head_nxt = head_inc;
    end

    if (cmd.enqueue || cmd.finished || cmd.serve) begin
      out_valid_nxt = 1'b1;
      sid_nxt       = 16'd0;
      sarr_nxt      = 16'd0;
      srem_nxt      = 16'd0;
      slice_nxt     = 16'd0;
    end

    if (cmd.enqueue) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        status_nxt = ST_ENQUEUED;
        count_nxt  = count_r + CNT_W'(1);
        if (pburst_r != 16'd0) begin
          unfin_nxt = unfin_r + CNT_W'(1);
        end
      end
    end

    if (cmd.finished) begin
      status_nxt = ST_FINISHED;
    end

    if (cmd.serve) begin
      status_nxt = ST_SERVED;
      sid_nxt    = rd_id_r;
      sarr_nxt   = rd_arr_r;
      srem_nxt   = rem_after;
      slice_nxt  = slice;
      head_nxt   = head_inc;
      if (rem_after == 16'd0) begin
        unfin_nxt = unfin_r - CNT_W'(1);
      end
    end

    done_nxt = (cmd.enqueue || cmd.finished || cmd.serve) ? (unfin_nxt == '0) : done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      unfin_r     <= '0;
      head_r      <= '0;
      quantum_r   <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      unfin_r     <= unfin_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pid_r    <= in_proc_id;
      parr_r   <= in_arrival_time;
      pburst_r <= in_burst_time;
    end
    status_r <= status_nxt;
    sid_r    <= sid_nxt;
    sarr_r   <= sarr_nxt;
    srem_r   <= srem_nxt;
    slice_r  <= slice_nxt;
    done_r   <= done_nxt;
  end

  always_ff @(posedge clk) begin
    if (enq_wr) begin
      mem_id[count_r[IDX_W-1:0]]  <= pid_r;
      mem_arr[count_r[IDX_W-1:0]] <= parr_r;
    end
    if (rem_wr) begin
      mem_rem[rem_addr] <= rem_data;
    end
    rd_id_r  <= mem_id[head_r];
    rd_arr_r <= mem_arr[head_r];
    rd_rem_r <= mem_rem[head_r];
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_served_id        = sid_r;
  assign out_served_arrival   = sarr_r;
  assign out_served_remaining = srem_r;
  assign out_slice_used       = slice_r;
  assign out_all_done         = done_r;

endmodule

/* hw/rtl/round_robin_quantum_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler
// Time-slice scheduler over a ring of process entries, one result per word.
// ----------------------------------------------------------------------------
// Usage. Words arrive on the in_ channel: in_kind low appends a process
// (identifier, arrival time, burst time) to the end of the ring, in_kind high
// runs one scheduling turn. Every accepted word gives exactly one result word
// on the out_ channel, in order. The quantum is written through cfg_wr_en and
// cfg_wr_data while the block is idle; it resets to one.
// Sequence. An enqueue or an all-finished turn loads its result in the ENQ or
// FIN state after acceptance. A served turn goes through READ and CHECK for
// each entry looked at, stepping over finished entries at the head, and
// serves from CHECK. The skip loop is set by the one registered read port of
// the entry memories: each entry looked at costs a read and a check state.
// One word is worked on at a time; the next word is taken on the cycle after
// the result is loaded, even while that result still waits on out_stall.
// Reset clears the entry count, the head pointer, the unfinished count and the
// result valid; entry memories are not cleared, as they are only read after
// being written. When the receiver stalls, the result word holds steady and the
// next word with its result ready waits in the controller until the result register frees.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_unit
  import rrq_pkg::*;
#(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_proc_id,
  input  logic [15:0] in_arrival_time,
  input  logic [15:0] in_burst_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_served_id,
  output logic [15:0] out_served_arrival,
  output logic [15:0] out_served_remaining,
  output logic [15:0] out_slice_used,
  output logic        out_all_done,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // Commands and status between the sequencer and the datapath.
  rrq_cmd_t cmd;
  rrq_sts_t sts;

  // The controller decides what each cycle does; it sees only the word's kind.
  rrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath holds the ring, the pointers, the quantum and the result.
  rrq_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_proc_id           (in_proc_id),
    .in_arrival_time      (in_arrival_time),
    .in_burst_time        (in_burst_time),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_served_id        (out_served_id),
    .out_served_arrival   (out_served_arrival),
    .out_served_remaining (out_served_remaining),
    .out_slice_used       (out_slice_used),
    .out_all_done         (out_all_done)
  );

endmodule

/* bench/tb_round_robin_quantum_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// Testbench for the round-robin quantum scheduler
// Drives enqueue and run words into the scheduler under random idling on both
// channels and checks every result word against a cycle-free predictor of the
// process ring that is kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_round_robin_quantum_scheduler_unit;
  import rrq_pkg::*;

  // Ring depth of the instance under test.
  localparam int RING_DEPTH = MAX_PROCESSES_DEF;

  // Word kinds on the input channel.
  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_RUN     = 1'b1;

  // Status codes on the result channel.
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_SERVED   = 2'd2;
  localparam logic [1:0] ST_ALL_DONE = 2'd3;

  // The slowest correct word costs a sender gap, the longest skip loop and a
  // receiver stall; the limit is several times the whole run, including the
  // long hold-off of the receiver.
  localparam int CYCLE_LIMIT = 400000;
  // Longest path through the block, one served turn after a full skip loop.
  localparam int DRAIN_CYCLES = 1 + 2 * RING_DEPTH + 8;
  // Length of the one long hold-off of the receiver, and when it happens.
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_RESULT = 60;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] id;
    logic [15:0] arrival;
    logic [15:0] remaining;
    logic [15:0] slice;
    logic        all_done;
  } sched_result_t;

  // Predicts the result word of every accepted word from its own copy of the
  // ring, and matches the result words of the block against those
  // predictions in order.
  class sched_scoreboard;
    logic [15:0] quantum;
    logic [15:0] ids [RING_DEPTH];
    logic [15:0] arrivals [RING_DEPTH];
    logic [15:0] rems [RING_DEPTH];
    int unsigned count;
    int unsigned head;
    sched_result_t expected_q [$];
    int unsigned results_seen;
    int unsigned failures;

    function new();
      quantum = 16'd1;
      count = 0;
      head = 0;
      results_seen = 0;
      failures = 0;
    endfunction

    function bit none_left();
      for (int i = 0; i < count; i++) begin
        if (rems[i] != 16'd0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int unsigned next_slot(int unsigned idx);
      return (idx + 1 >= count) ? 0 : idx + 1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Works out the result of one accepted input word.
    function void note_word(logic kind, logic [15:0] pid, logic [15:0] arr,
                            logic [15:0] burst);
      sched_result_t r;
      int unsigned tries;
      r = '0;
      if (kind == KIND_ENQUEUE) begin
        if (count >= RING_DEPTH) begin
          r.status = ST_REJECTED;
        end else begin
          ids[count] = pid;
          arrivals[count] = arr;
          rems[count] = burst;
          count++;
          r.status = ST_ENQUEUED;
        end
      end else if (none_left()) begin
        r.status = ST_ALL_DONE;
      end else begin
        if (head >= count) head = 0;
        // Finished entries at the head are stepped over.
        tries = 0;
        while (tries < count && rems[head] == 16'd0) begin
          head = next_slot(head);
          tries++;
        end
        r.slice = (rems[head] > quantum) ? quantum : rems[head];
        rems[head] = rems[head] - r.slice;
        r.id = ids[head];
        r.arrival = arrivals[head];
        r.remaining = rems[head];
        head = next_slot(head);
        r.status = ST_SERVED;
      end
      r.all_done = none_left();
      expected_q.push_back(r);
    endfunction

    function void report(string what, sched_result_t exp, sched_result_t got);
      failures++;
      if (failures <= 10) begin
        $display("result %0d %s", results_seen, what);
        $display("  expected status %0d id %h arrival %h remaining %h slice %h done %b",
                 exp.status, exp.id, exp.arrival, exp.remaining, exp.slice,
                 exp.all_done);
        $display("  actual   status %0d id %h arrival %h remaining %h slice %h done %b",
                 got.status, got.id, got.arrival, got.remaining, got.slice,
                 got.all_done);
      end
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("arrived with nothing expected", '0, got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status || got.id !== exp.id ||
          got.arrival !== exp.arrival || got.remaining !== exp.remaining ||
          got.slice !== exp.slice || got.all_done !== exp.all_done) begin
        report("does not match", exp, got);
      end
    endfunction

    // Anything still waiting at the end never arrived.
    function void close_out();
      while (expected_q.size() != 0) begin
        report("never arrived", expected_q.pop_front(), 'x);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [15:0] in_proc_id;
  logic [15:0] in_arrival_time;
  logic [15:0] in_burst_time;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_served_id;
  logic [15:0] out_served_arrival;
  logic [15:0] out_served_remaining;
  logic [15:0] out_slice_used;
  logic        out_all_done;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  sched_scoreboard sb;
  bit          in_fast;
  bit          out_fast;
  int unsigned cycle_count;

  round_robin_quantum_scheduler_unit i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_kind              (in_kind),
    .in_proc_id           (in_proc_id),
    .in_arrival_time      (in_arrival_time),
    .in_burst_time        (in_burst_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_served_id        (out_served_id),
    .out_served_arrival   (out_served_arrival),
    .out_served_remaining (out_served_remaining),
    .out_slice_used       (out_slice_used),
    .out_all_done         (out_all_done),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Watchdog: a run that hangs is ended here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Every result word taken at a rising edge is checked there. Stall only
  // changes at falling edges, so the sample does not race the block.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_status, out_served_id, out_served_arrival,
                        out_served_remaining, out_slice_used, out_all_done});
    end
  end

  // The receiver draws a random stall after each word it takes, with stretches
  // where it never stalls. Once in the run it holds off for a long stretch, so
  // that the block fills up and pushes back on its input while the sender keeps
  // offering words.
  initial begin : receiver
    int gap;
    int unsigned taken;
    out_stall = 1'b0;
    out_fast = 1'b0;
    taken = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        taken++;
        if (taken % 40 == 0) out_fast = ($urandom_range(0, 3) == 0);
        gap = out_fast ? 0 : $urandom_range(0, 19);
        if (taken == HOLD_AT_RESULT) gap = HOLD_CYCLES;
        if (gap > 0) begin
          @(negedge clk);
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Offers one word after a random gap and waits until the block takes it.
  // A word that follows with no gap keeps valid high, so valid is never
  // lowered and raised within the same step.
  task automatic send_word(logic kind, logic [15:0] pid, logic [15:0] arr,
                           logic [15:0] burst);
    int gap;
    gap = in_fast ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_proc_id <= pid;
    in_arrival_time <= arr;
    in_burst_time <= burst;
    do @(posedge clk); while (in_stall);
    sb.note_word(kind, pid, arr, burst);
  endtask

  task automatic run_turn();
    send_word(KIND_RUN, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Stops offering words and waits until every expected result has come.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // The quantum is only changed while the block has nothing in flight.
  task automatic set_quantum(logic [15:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.quantum = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Burst times mix finished-on-arrival entries, short ones that soon run
  // out and so leave gaps to skip, and the full 16-bit range.
  function automatic logic [15:0] rand_burst();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'($urandom_range(1, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  // A stretch of random words, mostly run turns. Enqueues keep coming once
  // the ring is full, so that rejection is hit again and again.
  task automatic random_phase(int n_words, int run_pct);
    logic kind;
    for (int k = 0; k < n_words; k++) begin
      if (k % 40 == 0) in_fast = ($urandom_range(0, 3) == 0);
      kind = ($urandom_range(0, 99) < run_pct) ? KIND_RUN : KIND_ENQUEUE;
      send_word(kind, 16'($urandom), 16'($urandom), rand_burst());
    end
  endtask

  initial begin : stimulus
    sb = new();
    cycle_count = 0;
    in_fast = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = KIND_ENQUEUE;
    in_proc_id = 16'd0;
    in_arrival_time = 16'd0;
    in_burst_time = 16'd0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 16'd0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reset quantum of one. A turn on an empty ring
    // reports all finished, and so does a ring that holds only an entry that
    // arrived with no time at all.
    run_turn();
    send_word(KIND_ENQUEUE, 16'h0000, 16'h0000, 16'h0000);
    run_turn();
    // The next turn has to step over the finished entry at the head.
    send_word(KIND_ENQUEUE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_turn();
    send_word(KIND_ENQUEUE, 16'h5A5A, 16'hA5A5, 16'h0001);
    send_word(KIND_ENQUEUE, 16'h1234, 16'h8000, 16'h0002);
    run_turn();
    run_turn();
    run_turn();

    // A zero quantum serves an entry without using any of its time, yet
    // the head still moves on.
    set_quantum(16'h0000);
    run_turn();
    run_turn();

    // The largest quantum finishes each entry in one turn, ending with all
    // entries done and a turn that finds nothing left.
    set_quantum(16'hFFFF);
    run_turn();
    run_turn();
    run_turn();
    run_turn();
    run_turn();

    // Random part: the ring fills up, then runs down under several quanta.
    set_quantum(16'($urandom_range(2, 9)));
    random_phase(220, 70);
    set_quantum(16'h0001);
    random_phase(200, 80);
    set_quantum(16'($urandom_range(100, 3000)));
    random_phase(200, 80);
    set_quantum(16'h8000);
    random_phase(60, 80);
    set_quantum(16'hFFFF);
    random_phase(150, 75);

    // Let the last words through, then allow the block time to show any
    // word it should not have produced.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rrq_pkg.sv
hw/rtl/rrq_ctrl.sv
hw/rtl/rrq_datapath.sv
hw/rtl/round_robin_quantum_scheduler_unit.sv
bench/tb_round_robin_quantum_scheduler_unit.sv
